/* sv/joint_range_motor_sequencer_assert.svh */
// Assertion macros for the joint range motor sequencer checker.
// Each macro expects clk and rst_n to be visible in the scope where it is used.
`ifndef JOINT_RANGE_MOTOR_SEQUENCER_ASSERT_SVH
`define JOINT_RANGE_MOTOR_SEQUENCER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define JRMS_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define JRMS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* sv/jrms_pkg.sv */
// Shared types, widths and constants for the joint range motor sequencer.
// No dependencies; every other file of the block but the assertion header imports this package.
package jrms_pkg;

    // Field widths
    localparam int SUM_W       = 12;
    localparam int REF_W       = 13;
    localparam int MODE_W      = 2;
    localparam int LIMIT_W     = 9;
    localparam int SPEED_W     = 7;
    localparam int MINUTES_W   = 10;
    localparam int ANGLE_W     = 12;
    localparam int ELAPSED_W   = 16;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 13;

    // Number of 8-bit readings summed into one sample
    localparam int AVG_COUNT   = 10;

    // angle_tenths = floor(sum * ref_mv * 640 / (AVG_COUNT * 255000)) - 1900
    localparam int     PROD_W      = SUM_W + REF_W;
    localparam longint SCALE_NUM   = 640;
    localparam longint SCALE_DEN   = longint'(AVG_COUNT) * 255000;
    localparam int     NUM_W       = PROD_W + 10;
    localparam int     DEN_W       = $clog2(SCALE_DEN + 1);
    localparam int     RECIP_SHIFT = PROD_W + 2;
    localparam longint RECIP       = ((longint'(1) << RECIP_SHIFT) * SCALE_NUM) / SCALE_DEN;
    localparam longint Q_MAX       = ((longint'(1) << PROD_W) - 1) * SCALE_NUM / SCALE_DEN;
    localparam int     Q_W         = $clog2(Q_MAX + 2);
    localparam int     MUL_W       = RECIP_SHIFT + Q_W;
    localparam int     CMP_W       = ((Q_W > 13) ? Q_W : 13) + 2;

    localparam int ANGLE_OFFSET      = 1900;
    localparam int ANGLE_SAT         = 2047;
    localparam int TENTHS_PER_DEG    = 10;
    localparam int WINDOW_MARGIN     = 10;
    localparam int PERIODS_PER_MIN   = 60;

    typedef enum logic [MODE_W-1:0] {
        MODE_REPEAT  = 2'd0,
        MODE_STRETCH = 2'd1,
        MODE_BEND    = 2'd2
    } mode_t;

    localparam logic OP_START  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [CFG_ADDR_W-1:0] REG_MODE    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SPEED   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MINUTES = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_REF     = 3'd5;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [LIMIT_W-1:0] max_angle;
        logic signed [LIMIT_W-1:0] min_angle;
        logic [SPEED_W-1:0]        drive_speed;
        logic [MINUTES_W-1:0]      run_minutes;
        logic [REF_W-1:0]          ref_mv;
    } cfg_t;

    // Converter beat: op code, floor quotient, nonzero remainder flag
    typedef struct packed {
        logic           op;
        logic [Q_W-1:0] quot;
        logic           rem_nz;
    } conv_t;

endpackage

/* sv/jrms_stream_if.sv */
// Valid/ready channel interfaces for command and result beats.
// Depends on jrms_pkg for field widths.
interface jrms_cmd_if;
    import jrms_pkg::*;

    logic             valid;
    logic             ready;
    logic             op;
    logic [SUM_W-1:0] adc_sum;

    modport source (output valid, output op, output adc_sum, input ready);
    modport sink   (input valid, input op, input adc_sum, output ready);
endinterface

interface jrms_res_if;
    import jrms_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      motor_enable;
    logic                      motor_direction;
    logic [SPEED_W-1:0]        pwm_duty;
    logic                      run_done;
    logic signed [ANGLE_W-1:0] angle_tenths;

    modport source (output valid, output motor_enable, output motor_direction,
                    output pwm_duty, output run_done, output angle_tenths, input ready);
    modport sink   (input valid, input motor_enable, input motor_direction,
                    input pwm_duty, input run_done, input angle_tenths, output ready);
endinterface

/* sv/jrms_cfg_regs.sv */
// Configuration register file with a plain write port.
// Depends on jrms_pkg.
module jrms_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               we,
    input  logic [jrms_pkg::CFG_ADDR_W-1:0]    addr,
    input  logic [jrms_pkg::CFG_DATA_W-1:0]    data,
    output jrms_pkg::cfg_t                     cfg,
    output logic                               speed_wr
);
    import jrms_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (we)
        begin
            unique case (addr)
                REG_MODE:    cfg_next.mode        = data[MODE_W-1:0];
                REG_MAX:     cfg_next.max_angle   = data[LIMIT_W-1:0];
                REG_MIN:     cfg_next.min_angle   = data[LIMIT_W-1:0];
                REG_SPEED:   cfg_next.drive_speed = data[SPEED_W-1:0];
                REG_MINUTES: cfg_next.run_minutes = data[MINUTES_W-1:0];
                REG_REF:     cfg_next.ref_mv      = data[REF_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode        <= MODE_W'(MODE_REPEAT);
            cfg_reg.max_angle   <= LIMIT_W'(130);
            cfg_reg.min_angle   <= LIMIT_W'(8);
            cfg_reg.drive_speed <= SPEED_W'(1);
            cfg_reg.run_minutes <= MINUTES_W'(1);
            cfg_reg.ref_mv      <= REF_W'(3300);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg      = cfg_reg;
    // Pulse on a drive speed write: restores the speed after a finished run
    assign speed_wr = we && (addr == REG_SPEED);

endmodule

/* sv/jrms_angle_conv.sv */
// Pipelined sample-to-angle converter: product, reciprocal multiply,
// back-multiply and remainder correction. Depends on jrms_pkg and jrms_cmd_if.
module jrms_angle_conv (
    input  logic                          clk,
    input  logic                          rst_n,
    jrms_cmd_if.sink                      cmd,
    input  logic [jrms_pkg::REF_W-1:0]    ref_mv,
    output logic                          out_valid,
    input  logic                          out_ready,
    output jrms_pkg::conv_t               out_data
);
    import jrms_pkg::*;

    logic              v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic              rdy1, rdy2, rdy3, rdy4, rdy5;
    logic              op1_reg, op2_reg, op3_reg, op4_reg;
    logic [SUM_W-1:0]  sum1_reg;
    logic [PROD_W-1:0] prod2_reg;
    logic [Q_W-1:0]    qe3_reg, qe4_reg;
    logic [NUM_W-1:0]  num3_reg, num4_reg, qd4_reg;
    conv_t             res5_reg;

    logic [MUL_W-1:0]  recip_prod;
    logic [NUM_W-1:0]  num_calc;
    logic [NUM_W-1:0]  rem;
    conv_t             res5_next;

    // Each stage takes a beat when it is empty or its beat moves on
    assign rdy5      = !v5_reg || out_ready;
    assign rdy4      = !v4_reg || rdy5;
    assign rdy3      = !v3_reg || rdy4;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign cmd.ready = rdy1;

    assign recip_prod = MUL_W'(prod2_reg) * MUL_W'(RECIP);
    // times 640 as shift and add
    assign num_calc   = (NUM_W'(prod2_reg) << 9) + (NUM_W'(prod2_reg) << 7);

    // Estimate is at most one low: fold one divisor back in when needed
    always_comb
    begin
        rem              = num4_reg - qd4_reg;
        res5_next.op     = op4_reg;
        if (rem >= NUM_W'(SCALE_DEN))
        begin
            res5_next.quot   = qe4_reg + Q_W'(1);
            res5_next.rem_nz = (rem != NUM_W'(SCALE_DEN));
        end
        else
        begin
            res5_next.quot   = qe4_reg;
            res5_next.rem_nz = (rem != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= cmd.valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            op1_reg  <= cmd.op;
            sum1_reg <= cmd.adc_sum;
        end
        if (rdy2)
        begin
            op2_reg   <= op1_reg;
            prod2_reg <= PROD_W'(sum1_reg) * PROD_W'(ref_mv);
        end
        if (rdy3)
        begin
            op3_reg  <= op2_reg;
            qe3_reg  <= recip_prod[RECIP_SHIFT +: Q_W];
            num3_reg <= num_calc;
        end
        if (rdy4)
        begin
            op4_reg  <= op3_reg;
            qe4_reg  <= qe3_reg;
            num4_reg <= num3_reg;
            qd4_reg  <= NUM_W'(qe3_reg) * NUM_W'(SCALE_DEN);
        end
        if (rdy5)
        begin
            res5_reg <= res5_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_data  = res5_reg;

endmodule

/* sv/jrms_seq_ctrl.sv */
// Run sequencer: limit compares, excursion latch, period counter and the
// registered result beat. Depends on jrms_pkg and jrms_res_if.
module jrms_seq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  jrms_pkg::cfg_t     cfg,
    input  logic               speed_wr,
    input  logic               in_valid,
    output logic               in_ready,
    input  jrms_pkg::conv_t    in_data,
    jrms_res_if.source         res
);
    import jrms_pkg::*;

    function automatic logic signed [CMP_W-1:0] to_base(
        input logic signed [LIMIT_W-1:0] deg,
        input int                        margin
    );
        logic signed [CMP_W-1:0] deg_x;
        deg_x   = CMP_W'(deg);
        to_base = deg_x * CMP_W'(TENTHS_PER_DEG) + CMP_W'(ANGLE_OFFSET + margin);
    endfunction

    logic                  active_reg, active_next;
    logic                  latch_reg, latch_next;
    logic                  dir_reg, dir_next;
    logic                  cut_reg, cut_next;
    logic                  done_reg, done_next;
    logic [MODE_W-1:0]     run_mode_reg, run_mode_next;
    logic [ELAPSED_W-1:0]  elapsed_reg, elapsed_next;

    logic                      out_valid_reg;
    logic                      out_enable_reg;
    logic                      out_dir_reg;
    logic [SPEED_W-1:0]        out_duty_reg;
    logic                      out_done_reg;
    logic signed [ANGLE_W-1:0] out_angle_reg;
    logic signed [ANGLE_W-1:0] angle_next;

    logic                      load;
    logic signed [CMP_W-1:0]   q_s;
    logic signed [CMP_W-1:0]   lo_base, hi_base, dir_base, max_base, min_base;
    logic signed [CMP_W-1:0]   angle_full;
    logic [ELAPSED_W-1:0]      run_limit;
    logic                      low, high, past_dir, outside, count;

    assign in_ready = !out_valid_reg || res.ready;
    assign load     = in_valid && in_ready;

    assign q_s       = $signed(CMP_W'(in_data.quot));
    assign lo_base   = to_base(cfg.min_angle, WINDOW_MARGIN);
    assign hi_base   = to_base(cfg.max_angle, WINDOW_MARGIN);
    assign dir_base  = to_base(cfg.max_angle, -WINDOW_MARGIN);
    assign max_base  = to_base(cfg.max_angle, 0);
    assign min_base  = to_base(cfg.min_angle, 0);
    assign run_limit = ELAPSED_W'(cfg.run_minutes) * ELAPSED_W'(PERIODS_PER_MIN);

    // Exact compares against integer thresholds: below is quotient < base,
    // above is quotient > base or equal with a nonzero remainder
    assign low      = q_s < lo_base;
    assign high     = (q_s > hi_base) || ((q_s == hi_base) && in_data.rem_nz);
    assign past_dir = (q_s > dir_base) || ((q_s == dir_base) && in_data.rem_nz);
    assign outside  = low || high;
    assign angle_full = q_s - CMP_W'(ANGLE_OFFSET);

    always_comb
    begin
        active_next   = active_reg;
        latch_next    = latch_reg;
        dir_next      = dir_reg;
        cut_next      = cut_reg;
        done_next     = done_reg;
        run_mode_next = run_mode_reg;
        elapsed_next  = elapsed_reg;
        angle_next    = '0;
        count         = 1'b0;

        if (in_data.op == OP_START)
        begin
            run_mode_next = cfg.mode;
            latch_next    = 1'b0;
            elapsed_next  = '0;
            done_next     = 1'b0;
            active_next   = 1'b1;
            unique case (cfg.mode)
                MODE_REPEAT:  dir_next = dir_reg;
                MODE_STRETCH: dir_next = 1'b0;
                MODE_BEND:    dir_next = 1'b1;
                default:
                begin
                    active_next = 1'b0;
                    done_next   = 1'b1;
                end
            endcase
        end
        else
        begin
            if (angle_full > CMP_W'(ANGLE_SAT))
                angle_next = ANGLE_W'(ANGLE_SAT);
            else
                angle_next = angle_full[ANGLE_W-1:0];

            if (active_reg)
            begin
                unique case (run_mode_reg)
                    MODE_REPEAT:
                    begin
                        if (outside)
                        begin
                            if (!latch_reg)
                            begin
                                latch_next = 1'b1;
                                if (low)
                                    dir_next = 1'b0;
                                if (past_dir)
                                    dir_next = 1'b1;
                                count = 1'b1;
                            end
                        end
                        else
                        begin
                            latch_next = 1'b0;
                            count      = 1'b1;
                        end
                        if (count && (elapsed_reg != '1))
                            elapsed_next = elapsed_reg + ELAPSED_W'(1);
                        if (elapsed_next >= run_limit)
                        begin
                            active_next = 1'b0;
                            done_next   = 1'b1;
                            cut_next    = 1'b1;
                        end
                    end
                    MODE_STRETCH:
                    begin
                        if (q_s >= max_base)
                        begin
                            active_next = 1'b0;
                            done_next   = 1'b1;
                        end
                    end
                    MODE_BEND:
                    begin
                        if (!((q_s > min_base) || ((q_s == min_base) && in_data.rem_nz)))
                        begin
                            active_next = 1'b0;
                            done_next   = 1'b1;
                        end
                    end
                    default:
                    begin
                        active_next = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            latch_reg     <= 1'b0;
            dir_reg       <= 1'b0;
            cut_reg       <= 1'b0;
            done_reg      <= 1'b0;
            run_mode_reg  <= MODE_W'(MODE_REPEAT);
            elapsed_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (speed_wr)
                cut_reg <= 1'b0;
            else if (load)
                cut_reg <= cut_next;
            if (load)
            begin
                active_reg   <= active_next;
                latch_reg    <= latch_next;
                dir_reg      <= dir_next;
                done_reg     <= done_next;
                run_mode_reg <= run_mode_next;
                elapsed_reg  <= elapsed_next;
            end
            if (in_ready)
                out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_enable_reg <= active_next;
            out_dir_reg    <= dir_next;
            out_duty_reg   <= cut_next ? '0 : cfg.drive_speed;
            out_done_reg   <= done_next;
            out_angle_reg  <= angle_next;
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.motor_enable    = out_enable_reg;
    assign res.motor_direction = out_dir_reg;
    assign res.pwm_duty        = out_duty_reg;
    assign res.run_done        = out_done_reg;
    assign res.angle_tenths    = out_angle_reg;

endmodule

/* sv/joint_range_motor_sequencer.sv */
// Top level of the joint range motor sequencer.
// Depends on jrms_pkg, jrms_stream_if, jrms_cfg_regs, jrms_angle_conv, jrms_seq_ctrl.

// Each command beat yields exactly one result beat, in order. A start beat
// (op 0) arms the mode held in the mode register; a sample beat (op 1) carries
// the sum of AVG_COUNT 8-bit readings, is turned into an angle in tenths of a
// degree (floor of sum*ref_mv*64/255000, minus 1900, capped at 2047) and moves
// the run forward. The block takes one beat per clock unless the sink stalls. A
// beat passes five converter stages (input register, sum times reference,
// reciprocal multiply, back-multiply, remainder fix-up) and one in the
// sequencer, whose output register holds the result beat. Every stage has its
// own valid bit, so bubbles close up and a new command is taken while a finished
// result still waits on a stalled sink. Configuration is to be written through
// cfg_we/cfg_addr/cfg_data only while no beat is in flight (unenforced); a drive
// speed write also restores the speed after a repeat run has cut it.
module joint_range_motor_sequencer (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [jrms_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [jrms_pkg::CFG_DATA_W-1:0]    cfg_data,
    jrms_cmd_if.sink                           cmd,
    jrms_res_if.source                         result
);
    import jrms_pkg::*;

    cfg_t  cfg;
    logic  speed_wr;
    logic  conv_valid;
    logic  conv_ready;
    conv_t conv_data;

    // Register file: mode, limits, speed, run length, ADC reference
    jrms_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .we       (cfg_we),
        .addr     (cfg_addr),
        .data     (cfg_data),
        .cfg      (cfg),
        .speed_wr (speed_wr)
    );

    // Angle converter: quotient and remainder flag for exact limit compares
    jrms_angle_conv u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .ref_mv    (cfg.ref_mv),
        .out_valid (conv_valid),
        .out_ready (conv_ready),
        .out_data  (conv_data)
    );

    // Sequencer: advance the run state once per beat and register the result
    jrms_seq_ctrl u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .speed_wr (speed_wr),
        .in_valid (conv_valid),
        .in_ready (conv_ready),
        .in_data  (conv_data),
        .res      (result)
    );

endmodule

/* sv/jrms_checker.sv */
// Port-level checker for the joint range motor sequencer, bound to the top.
// Depends on jrms_pkg and joint_range_motor_sequencer_assert.svh.
`include "joint_range_motor_sequencer_assert.svh"

module jrms_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                res_valid,
    input logic                                res_ready,
    input logic                                motor_enable,
    input logic                                motor_direction,
    input logic [jrms_pkg::SPEED_W-1:0]        pwm_duty,
    input logic                                run_done,
    input logic signed [jrms_pkg::ANGLE_W-1:0] angle_tenths
);
    import jrms_pkg::*;

    // Every field of the result beat, packed for the hold check
    logic [SPEED_W+ANGLE_W+2:0] res_beat;

    assign res_beat = {motor_enable, motor_direction, pwm_duty, run_done, angle_tenths};

    // A stalled result beat holds
    `JRMS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_beat))

    // A running motor never reports a finished run
    `JRMS_ASSERT_IMPLY(a_run_state, res_valid, !(motor_enable && run_done))

    // The angle never falls below the sensor's zero point
    `JRMS_ASSERT_IMPLY(a_angle_floor, res_valid, $signed(angle_tenths) >= -ANGLE_OFFSET)

endmodule

bind joint_range_motor_sequencer jrms_checker u_jrms_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (result.valid),
    .res_ready       (result.ready),
    .motor_enable    (result.motor_enable),
    .motor_direction (result.motor_direction),
    .pwm_duty        (result.pwm_duty),
    .run_done        (result.run_done),
    .angle_tenths    (result.angle_tenths)
);

/* tb/sv/joint_range_motor_sequencer_test.sv */
// Self-checking test of the joint range motor sequencer: directed and random beats,
// each result checked against an in-bench predictor of the angle and the run sequencing.
// Depends on jrms_pkg, jrms_stream_if and joint_range_motor_sequencer.
`timescale 1ns / 100ps

module joint_range_motor_sequencer_test;
    import jrms_pkg::*;

    // Mode code that arms nothing; the package enum leaves it out
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // Divisor of the angle conversion: AVG_COUNT readings times 255000
    localparam longint ANGLE_DIV   = longint'(AVG_COUNT) * 255000;
    localparam int     QUIET_LIMIT = 4000;
    localparam int     SETTLE_CYC  = 10;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;

    jrms_cmd_if cmd_ch();
    jrms_res_if res_ch();

    joint_range_motor_sequencer u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .cmd      (cmd_ch),
        .result   (res_ch)
    );

    always #2 clk = ~clk;

    // One predicted result beat
    typedef struct packed {
        logic                      enable;
        logic                      dir;
        logic [SPEED_W-1:0]        duty;
        logic                      done;
        logic signed [ANGLE_W-1:0] angle;
    } drive_beat_t;

    drive_beat_t drive_beat_q[$];

    // Register copies, at their reset values
    logic [MODE_W-1:0]         cur_mode    = MODE_REPEAT;
    logic signed [LIMIT_W-1:0] cur_max_deg = 9'sd130;
    logic signed [LIMIT_W-1:0] cur_min_deg = 9'sd8;
    logic [SPEED_W-1:0]        cur_speed   = 7'd1;
    logic [MINUTES_W-1:0]      cur_minutes = 10'd1;
    logic [REF_W-1:0]          cur_ref_mv  = 13'd3300;

    // Sequencer state as the predictor tracks it
    logic              run_active   = 1'b0;
    logic              run_latched  = 1'b0;
    logic              run_dir      = 1'b0;
    logic              run_cut      = 1'b0;
    logic              run_finished = 1'b0;
    logic [MODE_W-1:0] run_mode     = MODE_REPEAT;
    int unsigned       run_elapsed  = 0;

    int mismatches    = 0;
    int random_beats  = 0;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int sink_hold_req = 0;
    int sink_hold_left = 0;

    // Exact compares of the true angle num/ANGLE_DIV - 1900 against t tenths
    function automatic logic tenths_below(input longint num, input longint t);
        longint base;
        base = t + ANGLE_OFFSET;
        if (base <= 0)
            return 1'b0;
        return num < base * ANGLE_DIV;
    endfunction

    function automatic logic tenths_above(input longint num, input longint t);
        longint base;
        base = t + ANGLE_OFFSET;
        if (base < 0)
            return 1'b1;
        return num > base * ANGLE_DIV;
    endfunction

    // Advance the sequencer by one beat and return the motor outputs it produces
    function automatic drive_beat_t advance_sequencer(input logic op,
                                                      input logic [SUM_W-1:0] sum);
        drive_beat_t r;
        longint      num;
        longint      hi_t;
        longint      lo_t;
        longint      ang;
        logic        low;
        logic        count;
        ang = 0;
        if (op == OP_START)
        begin
            // Restart from scratch, even over a live run; the speed cut survives
            run_mode     = cur_mode;
            run_latched  = 1'b0;
            run_elapsed  = 0;
            run_finished = 1'b0;
            run_active   = 1'b1;
            if (run_mode == MODE_STRETCH)
                run_dir = 1'b0;
            else if (run_mode == MODE_BEND)
                run_dir = 1'b1;
            else if (run_mode == MODE_UNUSED)
            begin
                run_active   = 1'b0;
                run_finished = 1'b1;
            end
        end
        else
        begin
            num  = longint'(sum) * longint'(cur_ref_mv) * 640;
            hi_t = longint'(cur_max_deg) * TENTHS_PER_DEG;
            lo_t = longint'(cur_min_deg) * TENTHS_PER_DEG;
            ang  = num / ANGLE_DIV - ANGLE_OFFSET;
            if (ang > ANGLE_SAT)
                ang = ANGLE_SAT;
            if (run_active)
            begin
                if (run_mode == MODE_REPEAT)
                begin
                    low   = tenths_below(num, lo_t + WINDOW_MARGIN);
                    count = 1'b0;
                    if (low || tenths_above(num, hi_t + WINDOW_MARGIN))
                    begin
                        // Reverse only on the first sample of an excursion
                        if (!run_latched)
                        begin
                            run_latched = 1'b1;
                            if (low)
                                run_dir = 1'b0;
                            if (tenths_above(num, hi_t - WINDOW_MARGIN))
                                run_dir = 1'b1;
                            count = 1'b1;
                        end
                    end
                    else
                    begin
                        run_latched = 1'b0;
                        count       = 1'b1;
                    end
                    if (count && run_elapsed < 32'hFFFF)
                        run_elapsed++;
                    if (run_elapsed >= int'(cur_minutes) * PERIODS_PER_MIN)
                    begin
                        run_active   = 1'b0;
                        run_finished = 1'b1;
                        run_cut      = 1'b1;
                    end
                end
                else if (run_mode == MODE_STRETCH)
                begin
                    if (!tenths_below(num, hi_t))
                    begin
                        run_active   = 1'b0;
                        run_finished = 1'b1;
                    end
                end
                else if (!tenths_above(num, lo_t))
                begin
                    run_active   = 1'b0;
                    run_finished = 1'b1;
                end
            end
        end
        r.enable = run_active;
        r.dir    = run_dir;
        r.duty   = run_cut ? '0 : cur_speed;
        r.done   = run_finished;
        r.angle  = ang[ANGLE_W-1:0];
        return r;
    endfunction

    // Scoreboard: check the result beat against the oldest prediction, then
    // predict for the command beat taken on the same edge
    always @(posedge clk)
    begin
        drive_beat_t want;
        if (rst_n === 1'b1)
        begin
            if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            begin
                if (drive_beat_q.size() == 0)
                begin
                    $error("result beat with no prediction waiting");
                    mismatches++;
                end
                else
                begin
                    want = drive_beat_q.pop_front();
                    if (res_ch.motor_enable !== want.enable)
                    begin
                        $error("motor_enable: expected %0d, got %0d",
                               want.enable, res_ch.motor_enable);
                        mismatches++;
                    end
                    if (res_ch.motor_direction !== want.dir)
                    begin
                        $error("motor_direction: expected %0d, got %0d",
                               want.dir, res_ch.motor_direction);
                        mismatches++;
                    end
                    if (res_ch.pwm_duty !== want.duty)
                    begin
                        $error("pwm_duty: expected %0d, got %0d", want.duty, res_ch.pwm_duty);
                        mismatches++;
                    end
                    if (res_ch.run_done !== want.done)
                    begin
                        $error("run_done: expected %0d, got %0d", want.done, res_ch.run_done);
                        mismatches++;
                    end
                    if (res_ch.angle_tenths !== want.angle)
                    begin
                        $error("angle_tenths: expected %0d, got %0d",
                               want.angle, res_ch.angle_tenths);
                        mismatches++;
                    end
                end
            end
            if (cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1)
                drive_beat_q.push_back(advance_sequencer(cmd_ch.op, cmd_ch.adc_sum));
        end
    end

    // Result sink: stall at random, or hold off for a requested stretch
    always @(negedge clk)
    begin
        if (sink_hold_req > 0)
        begin
            sink_hold_left = sink_hold_req;
            sink_hold_req  = 0;
        end
        if (sink_hold_left > 0)
        begin
            res_ch.ready <= 1'b0;
            sink_hold_left--;
        end
        else
            res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Watchdog: end the run when nothing moves on either channel for too long
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) ||
                (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // All driving tasks start and end just after a falling edge.

    // Offer one command beat, after a random gap, and hold it until taken
    task automatic send_beat(input logic op, input logic [SUM_W-1:0] sum);
        while ($urandom_range(99) < src_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.op      <= op;
        cmd_ch.adc_sum <= sum;
        do
            @(posedge clk);
        while (cmd_ch.ready !== 1'b1);
        @(negedge clk);
    endtask

    // Stop offering, wait for every predicted beat, then let the pipe settle
    task automatic drain_pipeline();
        cmd_ch.valid <= 1'b0;
        while (drive_beat_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    // Write one register and track it in the predictor's copy
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MODE:    cur_mode    = value[MODE_W-1:0];
            REG_MAX:     cur_max_deg = value[LIMIT_W-1:0];
            REG_MIN:     cur_min_deg = value[LIMIT_W-1:0];
            REG_SPEED:
            begin
                cur_speed = value[SPEED_W-1:0];
                run_cut   = 1'b0;
            end
            REG_MINUTES: cur_minutes = value[MINUTES_W-1:0];
            REG_REF:     cur_ref_mv  = value[REF_W-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Samples with no run armed: only the angle moves. Cover both ends of the
    // sum and of the reference, and the saturated angle.
    task automatic test_angle_conversion();
        drain_pipeline();
        write_reg(REG_REF, 13'd5000);
        send_beat(OP_SAMPLE, 12'd0);
        send_beat(OP_SAMPLE, 12'd2550);
        send_beat(OP_SAMPLE, 12'd4095);
        drain_pipeline();
        write_reg(REG_REF, 13'd1000);
        send_beat(OP_SAMPLE, 12'd2550);
        send_beat(OP_SAMPLE, 12'd1);
        drain_pipeline();
        write_reg(REG_REF, 13'd8191);
        send_beat(OP_SAMPLE, 12'd4095);
        drain_pipeline();
        write_reg(REG_REF, 13'd3300);
    endtask

    // A start with the unused mode code finishes at once
    task automatic test_unused_mode();
        drain_pipeline();
        write_reg(REG_MODE, 13'(MODE_UNUSED));
        send_beat(OP_START, '0);
        send_beat(OP_SAMPLE, 12'd1000);
    endtask

    // Stretch to zero degrees: 2294 sits just under it at 3300 mV, 2295 just over.
    // Bend to the lowest limit: only a zero sum reaches it.
    task automatic test_stretch_bend();
        drain_pipeline();
        write_reg(REG_MODE, 13'(MODE_STRETCH));
        write_reg(REG_MAX, 13'd0);
        send_beat(OP_START, '0);
        send_beat(OP_SAMPLE, 12'd2294);
        send_beat(OP_SAMPLE, 12'd2295);
        drain_pipeline();
        write_reg(REG_MODE, 13'(MODE_BEND));
        write_reg(REG_MIN, 13'(-190));
        send_beat(OP_START, '0);
        send_beat(OP_SAMPLE, 12'd100);
        send_beat(OP_SAMPLE, 12'd0);
    endtask

    // Zero run length ends the repeat run on its first sample and cuts the
    // speed; a speed write restores it, a start does not
    task automatic test_zero_length_run();
        drain_pipeline();
        write_reg(REG_MODE, 13'(MODE_REPEAT));
        write_reg(REG_MINUTES, 13'd0);
        send_beat(OP_START, '0);
        send_beat(OP_SAMPLE, 12'd1200);
        drain_pipeline();
        write_reg(REG_SPEED, 13'd100);
        send_beat(OP_START, '0);
        send_beat(OP_SAMPLE, 12'd2550);
    endtask

    // Repeat excursions at 3300 mV with window 8..140 degrees: 1000 is below,
    // 2450 inside, 4095 above the top; the second sample of an excursion
    // must not count or turn. Finish with a restart over a live run.
    task automatic test_repeat_excursion();
        drain_pipeline();
        write_reg(REG_MINUTES, 13'd1);
        write_reg(REG_MIN, 13'd8);
        write_reg(REG_MAX, 13'd140);
        send_beat(OP_START, '0);
        send_beat(OP_SAMPLE, 12'd1000);
        send_beat(OP_SAMPLE, 12'd1000);
        send_beat(OP_SAMPLE, 12'd2450);
        send_beat(OP_SAMPLE, 12'd4095);
        send_beat(OP_SAMPLE, 12'd4095);
        send_beat(OP_START, '0);
        send_beat(OP_SAMPLE, 12'd2450);
    endtask

    // Hold the sink off for a long stretch while beats keep coming, so the
    // pipe fills and the input stalls
    task automatic test_backpressure();
        int k;
        drain_pipeline();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        write_reg(REG_MODE, 13'(MODE_REPEAT));
        write_reg(REG_MINUTES, 13'd2);
        @(posedge clk);
        sink_hold_req = 300;
        @(negedge clk);
        send_beat(OP_START, '0);
        for (k = 0; k < 40; k++)
            send_beat(OP_SAMPLE, 12'($urandom_range(2550)));
        drain_pipeline();
    endtask

    // One run under fresh settings: start, then samples that mostly land near
    // the limits or anywhere in range, with a stray restart now and then
    task automatic run_random_block(input int n_samples);
        logic [MODE_W-1:0] mode_pick;
        int                lim;
        int                pick;
        int                k;
        longint            target_t;
        longint            sum_l;
        logic [SUM_W-1:0]  sum;
        drain_pipeline();
        mode_pick = ($urandom_range(11) == 0) ? MODE_UNUSED : 2'($urandom_range(2));
        write_reg(REG_MODE, 13'(mode_pick));
        lim = ($urandom_range(6) == 0) ? int'($urandom_range(511)) - 256
                                       : int'($urandom_range(330)) - 190;
        write_reg(REG_MAX, 13'(lim));
        lim = ($urandom_range(6) == 0) ? int'($urandom_range(511)) - 256
                                       : int'($urandom_range(330)) - 190;
        write_reg(REG_MIN, 13'(lim));
        write_reg(REG_SPEED, 13'($urandom_range(127)));
        pick = $urandom_range(19);
        if (pick < 6)
            write_reg(REG_MINUTES, 13'd0);
        else if (pick < 16)
            write_reg(REG_MINUTES, 13'd1);
        else if (pick < 19)
            write_reg(REG_MINUTES, 13'd2);
        else
            write_reg(REG_MINUTES, 13'($urandom_range(1023)));
        if ($urandom_range(6) == 0)
            write_reg(REG_REF, 13'($urandom_range(8191)));
        else
            write_reg(REG_REF, 13'($urandom_range(5000, 1000)));

        send_beat(OP_START, '0);
        for (k = 0; k < n_samples; k++)
        begin
            if ($urandom_range(24) == 0)
            begin
                send_beat(OP_START, 12'($urandom_range(4095)));
                continue;
            end
            pick = $urandom_range(19);
            if (pick < 3)
                sum = 12'($urandom_range(4095));
            else if (pick < 8 && cur_ref_mv != 0)
            begin
                // Aim a few tenths around a limit or a window edge
                target_t = ($urandom_range(1) ? longint'(cur_max_deg)
                                              : longint'(cur_min_deg)) * TENTHS_PER_DEG
                         + (longint'($urandom_range(4)) - 2) * WINDOW_MARGIN
                         + longint'($urandom_range(6)) - 3;
                sum_l = (target_t + ANGLE_OFFSET) * ANGLE_DIV / (longint'(cur_ref_mv) * 640)
                      + longint'($urandom_range(2)) - 1;
                if (sum_l < 0)
                    sum_l = 0;
                if (sum_l > 4095)
                    sum_l = 4095;
                sum = sum_l[SUM_W-1:0];
            end
            else
                sum = 12'($urandom_range(2550));
            send_beat(OP_SAMPLE, sum);
        end
        random_beats += n_samples + 1;
    endtask

    task automatic run_random_phase(input int src_pct, input int sink_pct, input int n_beats);
        int goal;
        goal          = random_beats + n_beats;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        while (random_beats < goal)
            run_random_block($urandom_range(120, 20));
    endtask

    initial
    begin
        // Drive every input to a known value before the first edge
        cmd_ch.valid   = 1'b0;
        cmd_ch.op      = OP_START;
        cmd_ch.adc_sum = '0;
        res_ch.ready   = 1'b0;
        cfg_we         = 1'b0;
        cfg_addr       = REG_MODE;
        cfg_data       = '0;
        rst_n          = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        src_idle_pct  = 12;
        sink_idle_pct = 70;
        test_angle_conversion();
        test_unused_mode();
        test_stretch_bend();
        test_zero_length_run();
        test_repeat_excursion();
        test_backpressure();

        run_random_phase(12, 70, 540);
        run_random_phase(70, 12, 540);
        run_random_phase(0, 0, 540);
        drain_pipeline();

        if (mismatches == 0 && drive_beat_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
